FILE: hw/rtl/bpv_pkg.sv
// Shared types, constants and curve tables for the battery pack voltage model.
// Used by bpv_serial_alu and battery_pack_voltage_model; depends on nothing.
package bpv_pkg;

  typedef enum logic {ALU_MUL, ALU_DIV} alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
    logic [5:0] top;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_rsp_t;

  typedef struct packed {
    logic [4:0]         knee;
    logic signed [31:0] v0;
    logic signed [31:0] vk;
    logic signed [25:0] s1;
    logic signed [25:0] s2;
  } curve_t;

  localparam logic CFG_TEMP = 1'b0;
  localparam logic CFG_STEP = 1'b1;

  localparam logic signed [63:0] ONE_Q24      = 64'sd16777216;
  localparam logic signed [63:0] V_3_0        = 64'sd50331648;
  localparam logic signed [63:0] V_2_4_NEXT   = 64'sd40265319;
  localparam logic signed [63:0] SOC_FULL     = 64'sd16106127;
  localparam logic signed [63:0] SOC_LOW_NEXT = 64'sd3355444;
  localparam logic signed [63:0] SOC_0_2      = 64'sd3355443;
  localparam logic signed [63:0] Q_0_78       = 64'sd3350074491;
  localparam logic signed [63:0] CHARGE_MAX   = 64'sd140737488355327;
  localparam logic [31:0] CHARGE_DEN  = 32'd1318359375;
  localparam logic [63:0] CHARGE_HALF = 64'd659179687;
  localparam logic [31:0] SOC_DIV     = 32'd9984;
  localparam logic [31:0] R1_SLOPE    = 32'd106184911;
  localparam logic [31:0] PACK_GAIN   = 32'd273000000;
  localparam logic [31:0] MV_DIV      = 32'd3000;
  localparam logic [18:0] PACK_MV_MAX = 19'd400000;

  function automatic curve_t curve_params(input logic [1:0] k);
    curve_t c;
    case (k)
      2'd0: c = '{5'd12, 32'sd50331648, 32'sd46976205, -26'sd299059, -26'sd2982616};
      2'd1: c = '{5'd13, 32'sd52009370, 32'sd48653926, -26'sd274586, -26'sd3019899};
      2'd2: c = '{5'd15, 32'sd53687091, 32'sd52009370, -26'sd117983, -26'sd5452595};
      default: c = '{5'd18, 32'sd55364813, 32'sd52009370, -26'sd194857, -26'sd18454938};
    endcase
    return c;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) r = 32'sh7fffffff;
    else if (x < -64'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

FILE: hw/rtl/bpv_serial_alu.sv
// Bit-serial multiply and restoring divide on unsigned magnitudes, one bit a cycle.
// Depends on bpv_pkg for the request and response types.
module bpv_serial_alu import bpv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  alu_req_t    req,
  input  logic [63:0] req_a,
  input  logic [31:0] req_b,
  output alu_rsp_t    rsp,
  output logic [63:0] result
);

  logic        busy_r;
  logic        done_r;
  alu_op_t     op_r;
  logic [5:0]  cnt_r;
  logic [63:0] a_r;
  logic [31:0] b_r;
  logic [63:0] acc_r;
  logic [31:0] rem_r;

  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        ge;

  always_comb begin
    rem_sh  = {rem_r, a_r[cnt_r]};
    ge      = rem_sh >= {1'b0, b_r};
    rem_sub = rem_sh - {1'b0, b_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        cnt_r  <= req.top;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req_a;
      b_r   <= req_b;
      acc_r <= '0;
      rem_r <= '0;
    end else if (busy_r) begin
      if (op_r == ALU_MUL) begin
        if (b_r[0]) acc_r <= acc_r + a_r;
        a_r <= a_r << 1;
        b_r <= b_r >> 1;
      end else begin
        rem_r <= ge ? rem_sub[31:0] : rem_sh[31:0];
        acc_r <= {acc_r[62:0], ge};
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign result   = acc_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n) req.start |-> !busy_r)
    else $error("alu start while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("alu done without a run");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && op_r == ALU_DIV) |-> rem_r < b_r)
    else $error("divider remainder out of range");

endmodule

FILE: hw/rtl/battery_pack_voltage_model.sv
// Battery pack voltage model: charge account, curve lookup, pack voltage per item.
// Depends on bpv_pkg and bpv_serial_alu.
//
//  channel | direction | ports                                   | handshake
//  in      | input     | in_current_ma                           | in_valid / in_stall
//  out     | output    | out_pack_voltage_mv, out_battery_full,  | out_valid / out_stall
//          |           | out_cell_voltage_low                    |
//  cfg     | input     | cfg_index, cfg_data                     | cfg_we
//
// An item is computed in fourteen serial multiply or divide runs of
// 8 to 59 bits each on the one shared bit-serial unit (thirteen when the pack
// numerator is not positive).
// Reset sets 0.78 Ah, first step pending, -9.1 C and 100 us.
// A finished item waits in the output register; a new item is taken meanwhile,
// and it stalls only in its last step while that register is still full.
module battery_pack_voltage_model import bpv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [19:0] in_current_ma,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [18:0] out_pack_voltage_mv,
  output logic        out_battery_full,
  output logic        out_cell_voltage_low,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [19:0] cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_P_GO, ST_P_WAIT, ST_DLT_GO, ST_DLT_WAIT, ST_SOC_GO, ST_SOC_WAIT,
    ST_CV_GO, ST_CV_WAIT, ST_CR_GO, ST_CR_WAIT, ST_IV_GO, ST_IV_WAIT, ST_IVD_GO,
    ST_IVD_WAIT, ST_IR_GO, ST_IR_WAIT, ST_IRD_GO, ST_IRD_WAIT, ST_FIX, ST_M1_GO,
    ST_M1_WAIT, ST_M2_GO, ST_M2_WAIT, ST_NUM, ST_MV_WAIT, ST_OUT
  } state_t;

  state_t             state_r;
  logic [10:0]        temp_r;
  logic [19:0]        step_r;
  logic signed [47:0] q_r;
  logic               first_r;
  logic signed [19:0] cur_r;
  logic signed [31:0] soc_r;
  logic               sel_r;
  logic signed [31:0] va_r, vb_r, ra_r, rb_r, v_r, r_r, cv_base_r;
  logic               neg_r;
  logic [63:0]        tmp_r;
  logic signed [63:0] num_r;
  logic [18:0]        mv_r;
  logic               out_valid_r;
  logic [18:0]        out_mv_r;
  logic               out_full_r;
  logic               out_low_r;

  alu_req_t    alu_req;
  alu_rsp_t    alu_rsp;
  logic [63:0] alu_a;
  logic [31:0] alu_b;
  logic [63:0] alu_res;

  bpv_serial_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .req_a  (alu_a),
    .req_b  (alu_b),
    .rsp    (alu_rsp),
    .result (alu_res)
  );

  logic signed [11:0] t12;
  logic               lt_m100;
  logic [1:0]         ka, kb, kcur;
  logic signed [11:0] off_w;
  logic [7:0]         off, span;
  curve_t             crv;
  logic signed [48:0] q49, knee49, d49, d49_neg;
  logic [48:0]        dmag49;
  logic               gt;
  logic signed [25:0] slope, slope_neg;
  logic [24:0]        slope_mag;
  logic signed [31:0] base;
  logic signed [63:0] cv_prod, cv_wide;
  logic signed [31:0] cv_nxt;
  logic signed [63:0] soc64, d1, d1_neg, term, x5, r0, r1, r2, r3, cr_wide;
  logic [32:0]        d1mag;
  logic signed [31:0] cr_nxt;
  logic               ir_phase;
  logic signed [63:0] ia64, ib64, idiff, idiff_neg, quo64, i_wide;
  logic [32:0]        idmag;
  logic signed [31:0] i_nxt, veff, reff;
  logic [47:0]        qmag;
  logic signed [63:0] q64, delta, qsum, soc_wide, res_s;
  logic signed [47:0] q_nxt;
  logic signed [31:0] soc_nxt;
  logic [31:0]        vmag, rmag;
  logic [19:0]        cmag;
  logic [18:0]        mv_nxt;

  always_comb begin
    t12     = $signed({temp_r[10], temp_r});
    lt_m100 = t12 < -12'sd100;
    if (t12 < 12'sd0) begin
      ka = 2'd0; kb = 2'd1; off_w = t12 + 12'sd100; span = 8'd100;
    end else if (t12 < 12'sd100) begin
      ka = 2'd1; kb = 2'd2; off_w = t12; span = 8'd100;
    end else if (t12 < 12'sd250) begin
      ka = 2'd2; kb = 2'd3; off_w = t12 - 12'sd100; span = 8'd150;
    end else begin
      ka = 2'd3; kb = 2'd3; off_w = 12'sd0; span = 8'd1;
    end
    off  = lt_m100 ? 8'd0 : off_w[7:0];
    kcur = sel_r ? kb : ka;
    crv  = curve_params(kcur);

    q49     = $signed({q_r[47], q_r});
    knee49  = $signed({12'd0, crv.knee, 32'd0});
    gt      = q49 > knee49;
    d49     = gt ? q49 - knee49 : q49 - $signed(Q_0_78[48:0]);
    d49_neg = -d49;
    dmag49  = d49[48] ? d49_neg : d49;
    slope     = gt ? crv.s2 : crv.s1;
    slope_neg = -slope;
    slope_mag = slope[25] ? slope_neg[24:0] : slope[24:0];
    base      = gt ? crv.vk : crv.v0;
    cv_prod   = $signed({16'd0, alu_res[63:16]});
    cv_wide   = $signed({{32{cv_base_r[31]}}, cv_base_r}) + (neg_r ? -cv_prod : cv_prod);
    cv_nxt    = sat32(cv_wide);

    soc64  = $signed({{32{soc_r[31]}}, soc_r});
    d1     = soc64 - SOC_0_2;
    d1_neg = -d1;
    d1mag  = d1[63] ? d1_neg[32:0] : d1[32:0];
    term   = $signed({24'd0, alu_res[63:24]});
    x5     = soc64 * 64'sd5;
    r0     = 64'sd25 * ONE_Q24 - soc64 * 64'sd8;
    r2     = 64'sd10 * ONE_Q24 - x5;
    r3     = 64'sd5 * ONE_Q24 - ((x5 + $signed({63'd0, x5[63]})) >>> 1);
    if (soc64 < SOC_LOW_NEXT) r1 = 64'sd25 * ONE_Q24 - soc64 * 64'sd10;
    else r1 = 64'sd15 * ONE_Q24 + (neg_r ? -term : term);
    case (kcur)
      2'd0:    cr_wide = r0;
      2'd1:    cr_wide = r1;
      2'd2:    cr_wide = r2;
      default: cr_wide = r3;
    endcase
    cr_nxt = sat32(cr_wide);

    ir_phase  = state_r inside {ST_IR_GO, ST_IR_WAIT, ST_IRD_GO, ST_IRD_WAIT};
    ia64      = ir_phase ? $signed({{32{ra_r[31]}}, ra_r}) : $signed({{32{va_r[31]}}, va_r});
    ib64      = ir_phase ? $signed({{32{rb_r[31]}}, rb_r}) : $signed({{32{vb_r[31]}}, vb_r});
    idiff     = ib64 - ia64;
    idiff_neg = -idiff;
    idmag     = idiff[63] ? idiff_neg[32:0] : idiff[32:0];
    quo64     = $signed(alu_res);
    i_wide    = ia64 + (neg_r ? -quo64 : quo64);
    i_nxt     = i_wide[31:0];

    veff = (first_r || lt_m100) ? V_3_0[31:0] : v_r;
    reff = lt_m100 ? 32'sd419430400 : r_r;

    q64   = $signed({{16{q_r[47]}}, q_r});
    qmag  = q_r[47] ? 48'(-q_r) : q_r;
    res_s = $signed(alu_res);
    delta = neg_r ? -res_s : res_s;
    qsum  = q64 + delta;
    if (qsum > CHARGE_MAX) q_nxt = CHARGE_MAX[47:0];
    else if (qsum < -CHARGE_MAX - 64'sd1) q_nxt = 48'sh800000000000;
    else q_nxt = qsum[47:0];
    soc_wide = ONE_Q24 + (neg_r ? res_s : -res_s);
    soc_nxt  = sat32(soc_wide);

    vmag   = v_r[31] ? 32'(-v_r) : v_r;
    rmag   = r_r[31] ? 32'(-r_r) : r_r;
    cmag   = cur_r[19] ? 20'(-cur_r) : cur_r;
    mv_nxt = (alu_res > {45'd0, PACK_MV_MAX}) ? PACK_MV_MAX : alu_res[18:0];
  end

  always_comb begin
    alu_req = '{start: 1'b0, op: ALU_MUL, top: 6'd0};
    alu_a   = '0;
    alu_b   = '0;
    case (state_r)
      ST_P_GO: begin
        alu_req = '{start: 1'b1, op: ALU_MUL, top: 6'd19};
        alu_a   = {44'd0, cmag};
        alu_b   = {12'd0, step_r};
      end
      ST_DLT_GO: begin
        alu_req = '{start: 1'b1, op: ALU_DIV, top: 6'd58};
        alu_a   = (tmp_r << 19) + CHARGE_HALF;
        alu_b   = CHARGE_DEN;
      end
      ST_SOC_GO: begin
        alu_req = '{start: 1'b1, op: ALU_DIV, top: 6'd48};
        alu_a   = {15'd0, qmag, 1'b0};
        alu_b   = SOC_DIV;
      end
      ST_CV_GO: begin
        alu_req = '{start: 1'b1, op: ALU_MUL, top: 6'd24};
        alu_a   = {31'd0, dmag49[48:16]};
        alu_b   = {7'd0, slope_mag};
      end
      ST_CR_GO: begin
        alu_req = '{start: 1'b1, op: ALU_MUL, top: 6'd26};
        alu_a   = {31'd0, d1mag};
        alu_b   = R1_SLOPE;
      end
      ST_IV_GO, ST_IR_GO: begin
        alu_req = '{start: 1'b1, op: ALU_MUL, top: 6'd7};
        alu_a   = {31'd0, idmag};
        alu_b   = {24'd0, off};
      end
      ST_IVD_GO, ST_IRD_GO: begin
        alu_req = '{start: 1'b1, op: ALU_DIV, top: 6'd40};
        alu_a   = tmp_r;
        alu_b   = {24'd0, span};
      end
      ST_M1_GO: begin
        alu_req = '{start: 1'b1, op: ALU_MUL, top: 6'd28};
        alu_a   = {32'd0, vmag};
        alu_b   = PACK_GAIN;
      end
      ST_M2_GO: begin
        alu_req = '{start: 1'b1, op: ALU_MUL, top: 6'd19};
        alu_a   = {32'd0, rmag};
        alu_b   = {12'd0, cmag};
      end
      ST_NUM: begin
        alu_req = '{start: num_r > 64'sd0, op: ALU_DIV, top: 6'd37};
        alu_a   = {24'd0, num_r[63:24]};
        alu_b   = MV_DIV;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      temp_r      <= 11'h7a5;
      step_r      <= 20'd100;
      q_r         <= Q_0_78[47:0];
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TEMP: temp_r <= cfg_data[10:0];
          CFG_STEP: step_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall && state_r != ST_OUT) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            cur_r   <= in_current_ma;
            state_r <= ST_P_GO;
          end
        end
        ST_P_GO: begin
          neg_r   <= cur_r[19];
          state_r <= ST_P_WAIT;
        end
        ST_P_WAIT: begin
          if (alu_rsp.done) begin
            tmp_r   <= alu_res;
            state_r <= ST_DLT_GO;
          end
        end
        ST_DLT_GO: state_r <= ST_DLT_WAIT;
        ST_DLT_WAIT: begin
          if (alu_rsp.done) begin
            q_r     <= q_nxt;
            state_r <= ST_SOC_GO;
          end
        end
        ST_SOC_GO: begin
          neg_r   <= q_r[47];
          state_r <= ST_SOC_WAIT;
        end
        ST_SOC_WAIT: begin
          if (alu_rsp.done) begin
            soc_r   <= soc_nxt;
            sel_r   <= 1'b0;
            state_r <= ST_CV_GO;
          end
        end
        ST_CV_GO: begin
          cv_base_r <= base;
          neg_r     <= d49[48] ^ slope[25];
          state_r   <= ST_CV_WAIT;
        end
        ST_CV_WAIT: begin
          if (alu_rsp.done) begin
            if (sel_r) vb_r <= cv_nxt;
            else va_r <= cv_nxt;
            state_r <= ST_CR_GO;
          end
        end
        ST_CR_GO: begin
          neg_r   <= d1 > 64'sd0;
          state_r <= ST_CR_WAIT;
        end
        ST_CR_WAIT: begin
          if (alu_rsp.done) begin
            if (sel_r) begin
              rb_r    <= cr_nxt;
              state_r <= ST_IV_GO;
            end else begin
              ra_r    <= cr_nxt;
              sel_r   <= 1'b1;
              state_r <= ST_CV_GO;
            end
          end
        end
        ST_IV_GO: begin
          neg_r   <= idiff[63];
          state_r <= ST_IV_WAIT;
        end
        ST_IV_WAIT: begin
          if (alu_rsp.done) begin
            tmp_r   <= alu_res;
            state_r <= ST_IVD_GO;
          end
        end
        ST_IVD_GO: state_r <= ST_IVD_WAIT;
        ST_IVD_WAIT: begin
          if (alu_rsp.done) begin
            v_r     <= i_nxt;
            state_r <= ST_IR_GO;
          end
        end
        ST_IR_GO: begin
          neg_r   <= idiff[63];
          state_r <= ST_IR_WAIT;
        end
        ST_IR_WAIT: begin
          if (alu_rsp.done) begin
            tmp_r   <= alu_res;
            state_r <= ST_IRD_GO;
          end
        end
        ST_IRD_GO: state_r <= ST_IRD_WAIT;
        ST_IRD_WAIT: begin
          if (alu_rsp.done) begin
            r_r     <= i_nxt;
            state_r <= ST_FIX;
          end
        end
        ST_FIX: begin
          v_r     <= veff;
          r_r     <= reff;
          state_r <= ST_M1_GO;
        end
        ST_M1_GO: begin
          neg_r   <= v_r[31];
          state_r <= ST_M1_WAIT;
        end
        ST_M1_WAIT: begin
          if (alu_rsp.done) begin
            num_r   <= neg_r ? -res_s : res_s;
            state_r <= ST_M2_GO;
          end
        end
        ST_M2_GO: begin
          neg_r   <= r_r[31] ^ cur_r[19];
          state_r <= ST_M2_WAIT;
        end
        ST_M2_WAIT: begin
          if (alu_rsp.done) begin
            num_r   <= neg_r ? num_r + res_s : num_r - res_s;
            state_r <= ST_NUM;
          end
        end
        ST_NUM: begin
          if (num_r > 64'sd0) begin
            state_r <= ST_MV_WAIT;
          end else begin
            mv_r    <= 19'd0;
            state_r <= ST_OUT;
          end
        end
        ST_MV_WAIT: begin
          if (alu_rsp.done) begin
            mv_r    <= mv_nxt;
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_mv_r    <= mv_r;
            out_full_r  <= soc64 > SOC_FULL;
            out_low_r   <= $signed({{32{v_r[31]}}, v_r}) < V_2_4_NEXT;
            first_r     <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall             = state_r != ST_IDLE;
  assign out_valid            = out_valid_r;
  assign out_pack_voltage_mv  = out_mv_r;
  assign out_battery_full     = out_full_r;
  assign out_cell_voltage_low = out_low_r;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && out_valid_r && out_stall) |=> state_r == ST_OUT)
    else $error("finished item overwrote a waiting result");
  a_mv_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_mv_r <= PACK_MV_MAX)
    else $error("pack voltage above range");
  a_curve_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CR_WAIT && alu_rsp.done && sel_r) |=> state_r == ST_IV_GO)
    else $error("curve pair sequencing slip");
  a_alu_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_OUT) |-> !alu_rsp.busy)
    else $error("serial unit busy outside an item");

endmodule

FILE: test/tb_battery_pack_voltage_model.sv
// Testbench for battery_pack_voltage_model: drives pack currents, predicts every pack reading
// in fixed point, and checks readings under changing temperature, step time and idle patterns.
// Depends on bpv_pkg and the battery_pack_voltage_model RTL.
module tb_battery_pack_voltage_model;
  import bpv_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASES = 24;
  localparam int PHASE_ITEMS = 70;
  localparam int HOLD_CYCLES = 3000;

  typedef struct {
    logic [18:0] mv;
    logic        full;
    logic        low;
  } pack_reading_t;

  typedef struct {
    int          cur;
    bit          typed;
    pack_reading_t reading;
  } current_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [19:0] in_current_ma;
  logic        out_valid;
  logic        out_stall;
  logic [18:0] out_pack_voltage_mv;
  logic        out_battery_full;
  logic        out_cell_voltage_low;
  logic        cfg_we;
  logic        cfg_index;
  logic [19:0] cfg_data;

  pack_reading_t readings_due[$];
  longint charge_q32;
  bit     first_pending;
  logic [10:0] temp_reg;
  logic [19:0] step_reg;
  int errors;
  int readings_seen;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_request;
  int idle_count;

  battery_pack_voltage_model u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint sat_q24(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint cell_ocv(input logic [1:0] k, input longint q);
    curve_t c;
    longint knee, base, slope, dq;
    c = curve_params(k);
    knee = longint'(c.knee) <<< 32;
    if (q > knee) begin
      base = c.vk;
      slope = c.s2;
      dq = q - knee;
    end else begin
      base = c.v0;
      slope = c.s1;
      dq = q - Q_0_78;
    end
    dq = dq / 65536;
    return sat_q24(base + (slope * dq) / 65536);
  endfunction

  function automatic longint cell_res(input logic [1:0] k, input longint soc);
    longint r;
    case (k)
      2'd0: r = 25 * ONE_Q24 - 8 * soc;
      2'd1: begin
        if (soc < SOC_LOW_NEXT) r = 25 * ONE_Q24 - 10 * soc;
        else r = 15 * ONE_Q24 + (-64'sd106184911 * (soc - SOC_0_2)) / ONE_Q24;
      end
      2'd2: r = 10 * ONE_Q24 - 5 * soc;
      default: r = 5 * ONE_Q24 - (soc * 5) / 2;
    endcase
    return sat_q24(r);
  endfunction

  function automatic longint blend(input longint a, input longint b, input longint off,
                                   input longint span);
    return a + ((b - a) * off) / span;
  endfunction

  function automatic pack_reading_t step_pack(input logic [19:0] cur_bits);
    pack_reading_t res;
    longint cur, t, p, mag, delta, q, soc, v, r, num, mv, off, span;
    logic [1:0] ka, kb;
    cur = longint'($signed(cur_bits));
    t = longint'($signed(temp_reg));
    p = longint'({44'd0, step_reg}) * cur;
    mag = p < 0 ? -p : p;
    delta = (mag * 524288 + 659179687) / 1318359375;
    if (p < 0) delta = -delta;
    q = charge_q32 + delta;
    if (q > CHARGE_MAX) q = CHARGE_MAX;
    if (q < -CHARGE_MAX - 1) q = -CHARGE_MAX - 1;
    charge_q32 = q;
    soc = sat_q24(ONE_Q24 - (q * 2) / 9984);
    v = V_3_0;
    r = 25 * ONE_Q24;
    if (t >= -100) begin
      if (t < 0) begin
        ka = 0; kb = 1; off = t + 100; span = 100;
      end else if (t < 100) begin
        ka = 1; kb = 2; off = t; span = 100;
      end else if (t < 250) begin
        ka = 2; kb = 3; off = t - 100; span = 150;
      end else begin
        ka = 3; kb = 3; off = 0; span = 1;
      end
      v = blend(cell_ocv(ka, q), cell_ocv(kb, q), off, span);
      r = blend(cell_res(ka, soc), cell_res(kb, soc), off, span);
    end
    if (first_pending) v = V_3_0;
    first_pending = 1'b0;
    num = v * 91000 * 3000 - r * cur;
    if (num <= 0) mv = 0;
    else begin
      mv = num / (3000 * ONE_Q24);
      if (mv > 400000) mv = 400000;
    end
    res.mv = mv[18:0];
    res.full = soc > SOC_FULL;
    res.low = v < V_2_4_NEXT;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic write_reg(input logic idx, input logic [19:0] data);
    in_valid <= 1'b0;
    while (readings_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == CFG_TEMP) temp_reg = data[10:0];
    else step_reg = data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_temp(input int deci_c);
    logic [10:0] t;
    t = 11'(deci_c);
    write_reg(CFG_TEMP, {9'($urandom), t});
  endtask

  // call at a falling edge; returns at a falling edge
  task automatic send_current(input logic [19:0] cur, input bit typed = 0,
                              input pack_reading_t typed_reading = '{0, 0, 0});
    pack_reading_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_current_ma <= cur;
    do @(posedge clk); while (in_stall);
    pred = step_pack(cur);
    readings_due.push_back(typed ? typed_reading : pred);
    @(negedge clk);
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        out_stall <= 1'b1;
        hold_request--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin
    pack_reading_t exp_r;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        readings_seen++;
        if (readings_due.size() == 0) begin
          report_mismatch("pack reading with none expected");
        end else begin
          exp_r = readings_due.pop_front();
          if (out_pack_voltage_mv !== exp_r.mv)
            report_mismatch($sformatf("pack_voltage_mv %0d, want %0d",
                                      out_pack_voltage_mv, exp_r.mv));
          if (out_battery_full !== exp_r.full)
            report_mismatch($sformatf("battery_full %b, want %b",
                                      out_battery_full, exp_r.full));
          if (out_cell_voltage_low !== exp_r.low)
            report_mismatch($sformatf("cell_voltage_low %b, want %b",
                                      out_cell_voltage_low, exp_r.low));
        end
      end
    end
  end

  initial begin
    idle_count = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_count = 0;
      else idle_count++;
      if (idle_count >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    current_row_t rows[$];
    int temps[$];
    int kind, amp;
    logic [19:0] cur;
    rows = '{
      '{0, 1, '{19'd273000, 1'b1, 1'b0}},
      '{400000, 0, '{0, 0, 0}},
      '{-400000, 0, '{0, 0, 0}},
      '{524287, 0, '{0, 0, 0}},
      '{-524288, 0, '{0, 0, 0}},
      '{1, 0, '{0, 0, 0}},
      '{-1, 0, '{0, 0, 0}},
      '{0, 0, '{0, 0, 0}},
      '{174762, 0, '{0, 0, 0}},
      '{-349526, 0, '{0, 0, 0}}
    };
    temps = '{-1024, -400, -101, -100, -1, 0, 99, 100, 249, 250, 600, 1023};
    errors = 0;
    readings_seen = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_current_ma = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_TEMP;
    cfg_data = '0;
    out_stall = 1'b0;
    charge_q32 = Q_0_78;
    first_pending = 1'b1;
    temp_reg = 11'h7A5;
    step_reg = 20'd100;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) send_current(20'(rows[i].cur), rows[i].typed, rows[i].reading);
    write_reg(CFG_STEP, 20'd1000000);
    foreach (temps[i]) begin
      set_temp(temps[i]);
      send_current(20'sd400000);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 62; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 62; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      case ($urandom_range(3))
        0: set_temp(temps[$urandom_range(temps.size() - 1)]);
        default: set_temp($urandom_range(2047));
      endcase
      kind = (ph < 6 || ph >= 22) ? 0 : (ph < 16 ? 1 : 2);
      case (kind == 0 ? $urandom_range(3) : 1 + $urandom_range(1))
        0: write_reg(CFG_STEP, 20'd1);
        1: write_reg(CFG_STEP, 20'd1000000);
        2: write_reg(CFG_STEP, 20'hFFFFF);
        default: write_reg(CFG_STEP, 20'($urandom_range(20'hFFFFF)));
      endcase
      if (ph == 3) hold_request = HOLD_CYCLES;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        amp = $urandom_range(524287);
        case (kind)
          1: cur = $urandom_range(7) == 0 ? 20'($urandom) : 20'(amp);
          2: cur = $urandom_range(7) == 0 ? 20'($urandom) : 20'(-amp);
          default: cur = 20'($urandom);
        endcase
        send_current(cur);
      end
    end
    in_valid <= 1'b0;

    while (readings_due.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
    $display("run covered %0d pack readings over %0d phases of temperature, step time",
             readings_seen, PHASES);
    $display("and idle pattern, with one long output hold-off");
    if (errors == 0 && readings_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d readings outstanding", errors, readings_due.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
